// File: sv/sdvh_pkg.sv
`timescale 1ns / 1ps

package sdvh_pkg;

    localparam int CURVES      = 5;
    localparam int MAX_ENTRIES = 9;

    localparam int STEP_W  = 4;
    localparam int LEVEL_W = 3;
    localparam int SPEED_W = 8;
    localparam int GAIN_W  = 16;
    localparam int CHAN_W  = 8;

    localparam logic [CHAN_W-1:0]         MAIN_CHANNEL = 8'd0;
    localparam logic signed [GAIN_W-1:0]  UNSET_GAIN   = 16'sd1;
    localparam logic [SPEED_W-1:0]        SPEED_MAX    = 8'd255;
    localparam logic [LEVEL_W-1:0]        LEVEL_OFF    = 3'd0;

    localparam logic [1:0] AMP_INTERNAL = 2'd0;
    localparam logic [1:0] AMP_EXTERNAL = 2'd1;

    typedef enum logic [1:0] {
        FUNC_SPEED  = 2'd0,
        FUNC_VOLUME = 2'd1,
        FUNC_LEVEL  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [STEP_W-1:0] lo;
        logic [STEP_W-1:0] hi;
    } curve_steps_t;

    localparam logic [7:0] ENTER_THR [CURVES][MAX_ENTRIES] = '{
        '{8'd48, 8'd76, 8'd101, 8'd126, 8'd150, 8'd172, 8'd0,   8'd0,   8'd0},
        '{8'd48, 8'd71, 8'd93,  8'd114, 8'd134, 8'd155, 8'd172, 8'd0,   8'd0},
        '{8'd48, 8'd66, 8'd84,  8'd101, 8'd119, 8'd137, 8'd155, 8'd172, 8'd0},
        '{8'd40, 8'd55, 8'd69,  8'd84,  8'd98,  8'd113, 8'd127, 8'd142, 8'd156},
        '{8'd32, 8'd43, 8'd55,  8'd66,  8'd77,  8'd89,  8'd100, 8'd111, 8'd122}
    };

    localparam logic [7:0] LEAVE_THR [CURVES][MAX_ENTRIES] = '{
        '{8'd32, 8'd60, 8'd85, 8'd109, 8'd134, 8'd156, 8'd0,   8'd0,   8'd0},
        '{8'd32, 8'd55, 8'd76, 8'd97,  8'd118, 8'd138, 8'd156, 8'd0,   8'd0},
        '{8'd32, 8'd50, 8'd68, 8'd85,  8'd103, 8'd121, 8'd138, 8'd156, 8'd0},
        '{8'd24, 8'd39, 8'd53, 8'd68,  8'd82,  8'd97,  8'd111, 8'd126, 8'd140},
        '{8'd16, 8'd27, 8'd39, 8'd50,  8'd61,  8'd72,  8'd84,  8'd95,  8'd106}
    };

    localparam logic [STEP_W-1:0] ENTRY_COUNT [CURVES] = '{
        4'd6, 4'd7, 4'd8, 4'd9, 4'd9
    };

endpackage

// File: sv/sdvh_curve.sv
`timescale 1ns / 1ps

module sdvh_curve
(
    input  logic [sdvh_pkg::LEVEL_W-1:0] level,
    input  logic [sdvh_pkg::SPEED_W-1:0] speed,
    output sdvh_pkg::curve_steps_t       steps
);
    import sdvh_pkg::*;

    logic                valid_curve;
    logic [2:0]          curve_idx;
    logic [STEP_W-1:0]   count;

    assign valid_curve = (level >= 3'd1) && (level <= 3'(CURVES));
    assign curve_idx   = valid_curve ? (level - 3'd1) : 3'd0;
    assign count       = valid_curve ? ENTRY_COUNT[curve_idx] : '0;

    always_comb
    begin
        steps.lo = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if ((STEP_W'(i) < count) && (speed >= ENTER_THR[curve_idx][i]))
            begin
                steps.lo = STEP_W'(i + 1);
            end
        end
        steps.hi = steps.lo;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if ((steps.lo == STEP_W'(i)) && (STEP_W'(i) < count) &&
                (speed >= LEAVE_THR[curve_idx][i]))
            begin
                steps.hi = STEP_W'(i + 1);
            end
        end
    end

endmodule

// File: sv/sdvh_gain.sv
`timescale 1ns / 1ps

module sdvh_gain
(
    input  logic [1:0]                          amp_kind,
    input  logic signed [sdvh_pkg::GAIN_W-1:0]  base,
    input  logic [sdvh_pkg::STEP_W-1:0]         bonus,
    output logic signed [sdvh_pkg::GAIN_W-1:0]  gain_out
);
    import sdvh_pkg::*;

    localparam int SUM_W = GAIN_W + 2;

    logic [10:0]             bonus_hundredths;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] capped;

    assign bonus_hundredths = 11'(bonus) * 11'd100;
    assign sum = $signed({{2{base[GAIN_W-1]}}, base}) + $signed({7'b0, bonus_hundredths});

    always_comb
    begin
        capped = sum;
        if ((amp_kind == AMP_INTERNAL) && (sum > 18'sd200))
        begin
            capped = 18'sd200;
        end
        if ((amp_kind == AMP_EXTERNAL) && (sum > 18'sd0))
        begin
            capped = 18'sd0;
        end
        if (capped > 18'sd32767)
        begin
            gain_out = 16'sh7FFF;
        end
        else if (capped < -18'sd32768)
        begin
            gain_out = 16'sh8000;
        end
        else
        begin
            gain_out = capped[GAIN_W-1:0];
        end
    end

endmodule

// File: sv/speed_dependent_volume_hysteresis_core.sv
`timescale 1ns / 1ps

// Speed-dependent volume with hysteresis. Requests enter through an input
// register and are handled in one pass of logic into a result register, so
// one request is taken every clock cycle while the master side does not stall,
// and a result, if the request makes one, goes out from the result register.
// The limit of one request per cycle is set by the state update: each request
// reads the speed, level, bonus and base gain that the previous one left.
// A speed request emits only when the bonus step leaves its hysteresis band,
// a main-channel volume request stores the base gain and always emits, and a
// level request emits when the level changes (to off: only if the bonus step
// was not zero). Boosted volumes while the base gain is still 1 are suppressed.
// The amp kind register must be written only while no request is in flight.
module speed_dependent_volume_hysteresis_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // amp_kind

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func [1:0], speed [11:2], level [14:12], channel [22:15], gain [38:23],
    // bit 39 zero.
    input  logic [39:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_out [7:0], gain_out [23:8].
    output logic [23:0] m_axis_tdata
);
    import sdvh_pkg::*;

    logic                        in_valid_reg;
    logic [38:0]                 in_data_reg;

    logic [1:0]                  amp_kind_reg;
    logic [SPEED_W-1:0]          speed_now_reg, speed_now_next;
    logic [LEVEL_W-1:0]          curve_level_reg, curve_level_next;
    logic [STEP_W-1:0]           bonus_step_reg, bonus_step_next;
    logic signed [GAIN_W-1:0]    base_gain_reg, base_gain_next;

    logic                        out_valid_reg;
    logic [23:0]                 out_data_reg;

    logic                        fire;
    func_t                       in_func;
    logic [9:0]                  in_speed;
    logic [LEVEL_W-1:0]          in_level;
    logic [CHAN_W-1:0]           in_channel;
    logic signed [GAIN_W-1:0]    in_gain;
    logic [SPEED_W-1:0]          speed_clamped;

    logic [LEVEL_W-1:0]          lookup_level;
    logic [SPEED_W-1:0]          lookup_speed;
    curve_steps_t                steps;

    logic signed [GAIN_W-1:0]    gain_base_sel;
    logic signed [GAIN_W-1:0]    main_gain;

    logic                        emit;
    logic                        emit_raw;
    logic [CHAN_W-1:0]           emit_channel;
    logic signed [GAIN_W-1:0]    emit_gain;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    assign in_func    = func_t'(in_data_reg[1:0]);
    assign in_speed   = in_data_reg[11:2];
    assign in_level   = in_data_reg[14:12];
    assign in_channel = in_data_reg[22:15];
    assign in_gain    = in_data_reg[38:23];

    assign speed_clamped = (|in_speed[9:8]) ? SPEED_MAX : in_speed[SPEED_W-1:0];

    // The speed request looks up the stored level at the new speed; the level
    // request looks up the new level at the stored speed.
    assign lookup_level = (in_func == FUNC_LEVEL) ? in_level : curve_level_reg;
    assign lookup_speed = (in_func == FUNC_LEVEL) ? speed_now_reg : speed_clamped;

    sdvh_curve u_curve
    (
        .level (lookup_level),
        .speed (lookup_speed),
        .steps (steps)
    );

    assign gain_base_sel = (in_func == FUNC_VOLUME) ? in_gain : base_gain_reg;

    sdvh_gain u_gain
    (
        .amp_kind (amp_kind_reg),
        .base     (gain_base_sel),
        .bonus    (bonus_step_next),
        .gain_out (main_gain)
    );

    always_comb
    begin
        speed_now_next   = speed_now_reg;
        curve_level_next = curve_level_reg;
        bonus_step_next  = bonus_step_reg;
        base_gain_next   = base_gain_reg;
        emit             = 1'b0;
        emit_raw         = 1'b0;
        case (in_func)
            FUNC_SPEED:
            begin
                speed_now_next = speed_clamped;
                if (curve_level_reg == LEVEL_OFF)
                begin
                    bonus_step_next = '0;
                end
                else if ((bonus_step_reg != steps.lo) && (bonus_step_reg != steps.hi))
                begin
                    bonus_step_next = (bonus_step_reg <= steps.lo) ? steps.lo : steps.hi;
                    emit            = (base_gain_reg != UNSET_GAIN);
                end
            end
            FUNC_VOLUME:
            begin
                emit = 1'b1;
                if (in_channel == MAIN_CHANNEL)
                begin
                    base_gain_next = in_gain;
                end
                else
                begin
                    emit_raw = 1'b1;
                end
            end
            FUNC_LEVEL:
            begin
                if (in_level != curve_level_reg)
                begin
                    curve_level_next = in_level;
                    if (in_level == LEVEL_OFF)
                    begin
                        if ((bonus_step_reg != '0) && (base_gain_reg != UNSET_GAIN))
                        begin
                            bonus_step_next = '0;
                            emit            = 1'b1;
                        end
                    end
                    else
                    begin
                        bonus_step_next = steps.lo;
                        emit            = (base_gain_reg != UNSET_GAIN);
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign emit_channel = emit_raw ? in_channel : MAIN_CHANNEL;
    assign emit_gain    = emit_raw ? in_gain : main_gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            amp_kind_reg    <= 2'd0;
            speed_now_reg   <= '0;
            curve_level_reg <= LEVEL_OFF;
            bonus_step_reg  <= '0;
            base_gain_reg   <= UNSET_GAIN;
        end
        else
        begin
            if (cfg_we)
            begin
                amp_kind_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire)
            begin
                out_valid_reg   <= emit;
                speed_now_reg   <= speed_now_next;
                curve_level_reg <= curve_level_next;
                bonus_step_reg  <= bonus_step_next;
                base_gain_reg   <= base_gain_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[38:0];
        end
        if (fire && emit)
        begin
            out_data_reg <= {emit_gain, emit_channel};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("Input stage is empty but does not take a request.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit) |=> m_axis_tvalid)
        else $error("A result was produced but is not presented.");

    assert property (@(posedge clk) disable iff (!rst_n)
        bonus_step_reg <= STEP_W'(MAX_ENTRIES))
        else $error("Bonus step is beyond the longest curve.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> ((steps.hi >= steps.lo) && (steps.hi <= steps.lo + 4'd1)))
        else $error("Curve upper step is not the lower step or the next one.");

endmodule

// File: dv/speed_dependent_volume_hysteresis_core_tb.sv
`timescale 1ns / 1ps

module speed_dependent_volume_hysteresis_core_tb;

    import sdvh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 150;
    localparam int PHASE_ITEMS    = 235;

    localparam logic [1:0] AMP_OPEN     = 2'd2;
    localparam logic [1:0] AMP_OPEN_ALT = 2'd3;
    localparam logic [1:0] AMP_PLAN [4] = '{AMP_EXTERNAL, AMP_OPEN_ALT, AMP_OPEN, AMP_INTERNAL};

    localparam int SPD_ENTER [5][9] = '{
        '{48, 76, 101, 126, 150, 172, 0, 0, 0},
        '{48, 71, 93, 114, 134, 155, 172, 0, 0},
        '{48, 66, 84, 101, 119, 137, 155, 172, 0},
        '{40, 55, 69, 84, 98, 113, 127, 142, 156},
        '{32, 43, 55, 66, 77, 89, 100, 111, 122}
    };
    localparam int SPD_LEAVE [5][9] = '{
        '{32, 60, 85, 109, 134, 156, 0, 0, 0},
        '{32, 55, 76, 97, 118, 138, 156, 0, 0},
        '{32, 50, 68, 85, 103, 121, 138, 156, 0},
        '{24, 39, 53, 68, 82, 97, 111, 126, 140},
        '{16, 27, 39, 50, 61, 72, 84, 95, 106}
    };
    localparam int CURVE_LEN [5] = '{6, 7, 8, 9, 9};

    typedef struct packed {
        logic signed [15:0] gain;
        logic [7:0]         channel;
        logic [2:0]         level;
        logic [9:0]         speed;
        func_t              func;
    } volume_req_t;

    typedef struct packed {
        logic signed [15:0] gain;
        logic [7:0]         channel;
    } volume_out_t;

    class volume_scoreboard;
        logic [1:0]  amp_kind;
        logic [7:0]  speed_now;
        logic [2:0]  curve_level;
        logic [3:0]  bonus_step;
        int          base_gain;
        volume_out_t expected_q[$];
        int          mismatches;

        function new();
            amp_kind    = AMP_INTERNAL;
            speed_now   = 8'd0;
            curve_level = 3'd0;
            bonus_step  = 4'd0;
            base_gain   = 1;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endfunction

        function void curve_steps(logic [2:0] lvl, logic [7:0] spd,
                                  output logic [3:0] lo, output logic [3:0] hi);
            int c;
            int n;
            lo = 4'd0;
            hi = 4'd0;
            if (lvl < 3'd1 || lvl > 3'd5)
                return;
            c = int'(lvl) - 1;
            n = CURVE_LEN[c];
            for (int i = 0; i < n; i++)
            begin
                if (int'(spd) >= SPD_ENTER[c][i])
                    lo = 4'(i + 1);
            end
            hi = lo;
            if (int'(lo) < n && int'(spd) >= SPD_LEAVE[c][lo])
                hi = lo + 4'd1;
        endfunction

        function int limit_gain(int g);
            if (amp_kind == AMP_INTERNAL && g > 200)
                g = 200;
            if (amp_kind == AMP_EXTERNAL && g > 0)
                g = 0;
            if (g > 32767)
                g = 32767;
            if (g < -32768)
                g = -32768;
            return g;
        endfunction

        function void push_gain(logic [7:0] ch, int g);
            volume_out_t res;
            res.channel = ch;
            res.gain    = g[15:0];
            expected_q.push_back(res);
        endfunction

        function int boosted(int g);
            return limit_gain(g + 100 * int'(bonus_step));
        endfunction

        // Works out the state update and the expected volume for one request.
        function void note_request(volume_req_t r);
            logic [3:0] lo;
            logic [3:0] hi;
            int         g;
            g = int'($signed(r.gain));
            case (r.func)
                FUNC_SPEED:
                begin
                    speed_now = (r.speed > 10'd255) ? 8'd255 : r.speed[7:0];
                    if (curve_level == LEVEL_OFF)
                    begin
                        bonus_step = 4'd0;
                        return;
                    end
                    curve_steps(curve_level, speed_now, lo, hi);
                    if (bonus_step == lo || bonus_step == hi)
                        return;
                    bonus_step = (bonus_step <= lo) ? lo : hi;
                    if (base_gain != 1)
                        push_gain(MAIN_CHANNEL, boosted(base_gain));
                end
                FUNC_VOLUME:
                begin
                    if (r.channel == MAIN_CHANNEL)
                    begin
                        base_gain = g;
                        push_gain(MAIN_CHANNEL, boosted(g));
                    end
                    else
                        push_gain(r.channel, g);
                end
                FUNC_LEVEL:
                begin
                    if (r.level == curve_level)
                        return;
                    curve_level = r.level;
                    if (r.level == LEVEL_OFF)
                    begin
                        if (bonus_step != 4'd0 && base_gain != 1)
                        begin
                            bonus_step = 4'd0;
                            push_gain(MAIN_CHANNEL, limit_gain(base_gain));
                        end
                        return;
                    end
                    curve_steps(r.level, speed_now, lo, hi);
                    bonus_step = lo;
                    if (base_gain != 1)
                        push_gain(MAIN_CHANNEL, boosted(base_gain));
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(volume_out_t got);
            volume_out_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected volume channel %0d gain %0d",
                                          got.channel, got.gain));
                return;
            end
            want = expected_q.pop_front();
            if (got.channel !== want.channel)
                report_mismatch($sformatf("channel_out %0d, expected %0d",
                                          got.channel, want.channel));
            if (got.gain !== want.gain)
                report_mismatch($sformatf("gain_out %0d, expected %0d",
                                          got.gain, want.gain));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    volume_scoreboard sb;
    bit               hold_pending;
    int               speed_walk;
    int               stall_cycles;

    speed_dependent_volume_hysteresis_core i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic volume_req_t make_req(func_t f, int spd, int lvl, int ch, int g);
        volume_req_t r;
        r.func    = f;
        r.speed   = spd[9:0];
        r.level   = lvl[2:0];
        r.channel = ch[7:0];
        r.gain    = g[15:0];
        return r;
    endfunction

    // Speed mostly follows a slow walk so that the hysteresis bands are crossed
    // in both directions; the rest is noise over the whole field.
    function automatic volume_req_t random_request();
        int pick;
        int spd;
        int ch;
        int g;
        int sel;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                spd = $urandom_range(0, 1023);
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    speed_walk = $urandom_range(0, 255);
                else
                    speed_walk = speed_walk + int'($urandom_range(0, 24)) - 12;
                if (speed_walk < 0)
                    speed_walk = 0;
                if (speed_walk > 270)
                    speed_walk = 270;
                spd = speed_walk;
            end
            return make_req(FUNC_SPEED, spd, $urandom, $urandom, $urandom);
        end
        if (pick < 80)
        begin
            ch = ($urandom_range(0, 9) < 6) ? int'(MAIN_CHANNEL) : int'($urandom_range(0, 255));
            sel = $urandom_range(0, 9);
            if (sel < 7)
                g = int'($urandom_range(0, 6000)) - 3000;
            else if (sel < 9)
                g = $urandom;
            else
            begin
                case ($urandom_range(0, 4))
                    0: g = 1;
                    1: g = 32767;
                    2: g = -32768;
                    3: g = 200;
                    default: g = 0;
                endcase
            end
            return make_req(FUNC_VOLUME, $urandom, $urandom, ch, g);
        end
        if (pick < 95)
            return make_req(FUNC_LEVEL, $urandom, ($urandom_range(0, 3) == 0) ?
                            $urandom_range(0, 7) : $urandom_range(1, 5), $urandom, $urandom);
        return make_req(FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic send_request(volume_req_t r);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(r);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic await_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle_block();
        pause_sender(1);
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_amp(logic [1:0] kind);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= kind;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.amp_kind = kind;
    endtask

    task automatic probe_clamps();
        send_request(make_req(FUNC_LEVEL, 0, 5, 0, 0));
        send_request(make_req(FUNC_SPEED, 255, 0, 0, 0));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, 32767));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, -32768));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, 150));
    endtask

    task automatic run_phase(int count, bit pressure);
        int burst_left;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 8));
            end
            if (pressure && k == 60)
                hold_pending = 1'b1;
            if (pressure && k == 170)
            begin
                pause_sender(1);
                await_results();
            end
            send_request(random_request());
            burst_left--;
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 2'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_pending  = 1'b0;
        speed_walk    = 100;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_amp(AMP_INTERNAL);
        send_request(make_req(FUNC_NONE, 1023, 7, 255, -1));
        send_request(make_req(FUNC_SPEED, 1023, 0, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 5, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 0, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 0, 0, 0));
        send_request(make_req(FUNC_VOLUME, 0, 0, 255, -32768));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, 32767));
        send_request(make_req(FUNC_LEVEL, 0, 6, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 7, 0, 0));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, -500));
        send_request(make_req(FUNC_LEVEL, 0, 1, 0, 0));
        send_request(make_req(FUNC_SPEED, 0, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 40, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 50, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 35, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 31, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 255, 0, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 0, 0, 0));
        send_request(make_req(FUNC_SPEED, 130, 0, 0, 0));
        send_request(make_req(FUNC_LEVEL, 0, 4, 0, 0));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, 1));
        send_request(make_req(FUNC_SPEED, 200, 0, 0, 0));
        send_request(make_req(FUNC_VOLUME, 0, 0, MAIN_CHANNEL, 0));
        send_request(make_req(FUNC_NONE, 0, 0, 0, 0));

        for (int p = 0; p < 4; p++)
        begin
            settle_block();
            write_amp(AMP_PLAN[p]);
            probe_clamps();
            run_phase(PHASE_ITEMS, p == 1);
        end

        pause_sender(1);
        await_results();
        repeat (12) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** speed_dependent_volume_hysteresis_core: PASSED **");
        else
            $display("** speed_dependent_volume_hysteresis_core: FAILED **");
        $finish;
    end

    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        m_axis_tready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1) == 0;
                    2: m_axis_tready <= $urandom_range(0, 3) == 0;
                    default: m_axis_tready <= $urandom_range(0, 6) != 0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(volume_out_t'(m_axis_tdata));
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** speed_dependent_volume_hysteresis_core: FAILED **");
                $finish;
            end
        end
    end

endmodule

// File: speed_dependent_volume_hysteresis_core.f
sv/sdvh_pkg.sv
sv/sdvh_curve.sv
sv/sdvh_gain.sv
sv/speed_dependent_volume_hysteresis_core.sv
dv/speed_dependent_volume_hysteresis_core_tb.sv
